FILE: rtl/control_breakpoint_ramp_core_assert.svh
// assertion macros used by the checker of the control ramp core
`ifndef CONTROL_BREAKPOINT_RAMP_CORE_ASSERT_SVH
`define CONTROL_BREAKPOINT_RAMP_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CBR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("control ramp check failed");

// next-cycle implication, disabled while reset is asserted
`define CBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("control ramp check failed");

`endif

FILE: rtl/cbr_pkg.sv
package cbr_pkg;

    // field widths
    localparam int FRAME_W  = 12;
    localparam int LEVEL_W  = 16;
    localparam int CARRY_W  = 14;
    localparam int CALC_W   = 15;                   // signed frame arithmetic
    localparam int SPAN_W   = 14;                   // positive frame distance
    localparam int DIFF_W   = LEVEL_W + 1;          // level difference
    localparam int PROD_W   = SPAN_W + LEVEL_W;     // dividend of the ramp
    localparam int DIV_CNT_W = $clog2(PROD_W);

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_FRAMES_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BUFFER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LEVEL     = 1'd1;
    localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET = 13'd256;
    localparam logic signed [LEVEL_W-1:0] INITIAL_LEVEL_RESET = 16'sd0;

    // lowest frame a carried breakpoint may take
    localparam logic signed [CARRY_W-1:0] CARRY_FLOOR = -14'sd4096;

    // parameter defaults
    localparam int MAX_BREAKPOINTS_DEF = 64;
    localparam int MAX_FRAMES_DEF      = 4096;

    // operation codes
    localparam logic OP_BREAKPOINT = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [FRAME_W-1:0]        frame;
    } bp_entry_t;

    localparam int BP_W = $bits(bp_entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_PREV,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_FINISH
    } cbr_state_t;

endpackage

FILE: rtl/cbr_ram.sv
module cbr_ram #(
    parameter int WIDTH = cbr_pkg::BP_W,
    parameter int DEPTH = cbr_pkg::MAX_BREAKPOINTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/control_breakpoint_ramp_core.sv
// Control lane ramp: turns timed breakpoints into one level per sample tick.
// An input word with s_tuser low stores a breakpoint (frame, level) for the
// current buffer; breakpoints must arrive in ascending frame order ahead of
// the ticks they shape, and those past the store capacity are dropped. An
// input word with s_tuser high is a sample tick and yields one output word:
// the level ramped linearly between the previous and the next breakpoint,
// the quotient truncated toward zero, held after the last breakpoint, with
// m_tlast set on the last tick of the buffer. At the end of a buffer the
// last breakpoint carries over as the start of the next ramp, its frame
// moved back by the buffer length and floored at -4096.
// A breakpoint is stored without leaving the idle state. A tick first
// steps the segment pointer over every stored breakpoint that lies before
// it; past the last one it holds the last level, on a segment end or on
// or before a segment start it takes that breakpoint's level, and else it
// interpolates: the ramp division runs one quotient bit per cycle, 30 bits,
// through a single shared subtract-and-compare stage. The block takes no new
// word while a tick is in flight; a finished level waits in the output
// register. Configuration writes are always taken, and are meant to be
// issued only while the block is idle. The initial_level index has no
// register behind it: the carried level resets to a package constant, so
// writes to it have no visible effect.
module control_breakpoint_ramp_core #(
    parameter int MAX_BREAKPOINTS = cbr_pkg::MAX_BREAKPOINTS_DEF,
    parameter int MAX_FRAMES      = cbr_pkg::MAX_FRAMES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cbr_pkg::S_TDATA_W-1:0]    s_tdata,   // frame [11:0], target_level [27:12]
    input  logic                             s_tuser,   // operation
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cbr_pkg::M_TDATA_W-1:0]    m_tdata,   // level [15:0]
    output logic                             m_tlast,   // end_of_buffer
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW     = $clog2(MAX_BREAKPOINTS);
    localparam int CW     = $clog2(MAX_BREAKPOINTS + 1);
    localparam int TICK_W = $clog2(MAX_FRAMES);
    localparam int LEN_W  = $clog2(MAX_FRAMES + 1);

    localparam int FRAME_W  = cbr_pkg::FRAME_W;
    localparam int LEVEL_W  = cbr_pkg::LEVEL_W;
    localparam int CARRY_W  = cbr_pkg::CARRY_W;
    localparam int CALC_W   = cbr_pkg::CALC_W;
    localparam int SPAN_W   = cbr_pkg::SPAN_W;
    localparam int DIFF_W   = cbr_pkg::DIFF_W;
    localparam int PROD_W   = cbr_pkg::PROD_W;
    localparam int DIV_CNT_W = cbr_pkg::DIV_CNT_W;

    // sequencer
    cbr_pkg::cbr_state_t state_reg, state_next;

    // configuration
    logic [cbr_pkg::CFG_FRAMES_W-1:0] fpb_reg, fpb_next;

    // lane state
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic [TICK_W-1:0]            tick_reg, tick_next;
    logic signed [CARRY_W-1:0]    carry_frame_reg, carry_frame_next;
    logic signed [LEVEL_W-1:0]    carry_level_reg, carry_level_next;
    cbr_pkg::bp_entry_t           last_bp_reg, last_bp_next;

    // segment endpoints and ramp operands
    logic [FRAME_W-1:0]           nf_reg, nf_next;
    logic signed [LEVEL_W-1:0]    nv_reg, nv_next;
    logic signed [CARRY_W-1:0]    pf_reg, pf_next;
    logic signed [LEVEL_W-1:0]    pv_reg, pv_next;
    logic [SPAN_W-1:0]            span_reg, span_next;
    logic [SPAN_W-1:0]            dt_reg, dt_next;
    logic [LEVEL_W-1:0]           dv_mag_reg, dv_mag_next;
    logic                         neg_reg, neg_next;

    // divider
    logic [PROD_W-1:0]            quo_reg, quo_next;
    logic [SPAN_W-1:0]            rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]         div_cnt_reg, div_cnt_next;

    // result
    logic signed [LEVEL_W-1:0]    res_reg, res_next;
    logic                         m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0]           m_level_reg, m_level_next;
    logic                         m_last_reg, m_last_next;

    // breakpoint store
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [cbr_pkg::BP_W-1:0]     ram_rdata;
    cbr_pkg::bp_entry_t           in_entry;
    cbr_pkg::bp_entry_t           rd_entry;

    // helpers
    logic                         in_fire;
    logic                         store_full;
    logic [CW-1:0]                ptr_m1;
    logic [LEN_W-1:0]             buf_len;
    logic                         last_tick;
    logic                         out_free;
    logic                         rd_before_tick;
    logic                         walk_more;
    logic signed [CALC_W-1:0]     tick_s;
    logic signed [CALC_W-1:0]     nf_s;
    logic signed [CALC_W-1:0]     pf_s;
    logic signed [CALC_W-1:0]     span_full;
    logic signed [CALC_W-1:0]     dt_full;
    logic signed [DIFF_W-1:0]     dv;
    logic [PROD_W-1:0]            product;
    logic [SPAN_W:0]              rem_sh;
    logic [SPAN_W:0]              rem_sub;
    logic                         quo_bit;
    logic signed [DIFF_W-1:0]     q_s;
    logic signed [DIFF_W-1:0]     ramp_sum;
    logic signed [CALC_W-1:0]     carry_base;
    logic signed [CALC_W-1:0]     carry_diff;
    logic signed [CARRY_W-1:0]    carry_sat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == cbr_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;

    // level above frame, as packed on the input word
    assign in_entry = cbr_pkg::bp_entry_t'(s_tdata[cbr_pkg::BP_W-1:0]);
    assign rd_entry = cbr_pkg::bp_entry_t'(ram_rdata);

    assign store_full = (count_reg >= CW'(MAX_BREAKPOINTS));
    assign ram_we     = in_fire && (s_tuser == cbr_pkg::OP_BREAKPOINT) && !store_full;
    assign ram_waddr  = count_reg[AW-1:0];
    assign ptr_m1     = ptr_reg - 1'b1;

    // walk reads the pointed entry, then the entry before it
    assign ram_raddr = (state_reg == cbr_pkg::ST_WALK_CHK) ? ptr_m1[AW-1:0] : ptr_reg[AW-1:0];

    cbr_ram #(
        .WIDTH (cbr_pkg::BP_W),
        .DEPTH (MAX_BREAKPOINTS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // buffer length, clamped to 1..MAX_FRAMES
    always_comb begin
        if (fpb_reg == '0) begin
            buf_len = LEN_W'(1);
        end else if (int'(fpb_reg) > MAX_FRAMES) begin
            buf_len = LEN_W'(MAX_FRAMES);
        end else begin
            buf_len = LEN_W'(fpb_reg);
        end
    end

    assign last_tick = (({1'b0, tick_reg} + 1'b1) >= (TICK_W + 1)'(buf_len));
    assign out_free  = !m_valid_reg || m_tready;

    // signed frame domain
    assign tick_s    = $signed(CALC_W'(tick_reg));
    assign nf_s      = $signed(CALC_W'(nf_reg));
    assign pf_s      = CALC_W'(pf_reg);
    assign span_full = nf_s - pf_s;
    assign dt_full   = tick_s - pf_s;
    assign dv        = DIFF_W'(nv_reg) - DIFF_W'(pv_reg);

    assign walk_more      = (ptr_reg < count_reg);
    assign rd_before_tick = (CALC_W'(rd_entry.frame) < CALC_W'(tick_reg));

    // shared multiply and restoring divide step
    assign product = dt_reg * dv_mag_reg;
    assign rem_sh  = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, span_reg};
    assign quo_bit = (rem_sh >= {1'b0, span_reg});

    // quotient magnitude never exceeds the level difference
    assign q_s      = $signed({1'b0, quo_reg[LEVEL_W-1:0]});
    assign ramp_sum = DIFF_W'(pv_reg) + (neg_reg ? -q_s : q_s);

    // carried breakpoint frame at the end of a buffer
    assign carry_base = (count_reg != '0) ? $signed(CALC_W'(last_bp_reg.frame))
                                          : CALC_W'(carry_frame_reg);
    assign carry_diff = carry_base - $signed(CALC_W'(buf_len));
    assign carry_sat  = (carry_diff < CALC_W'(cbr_pkg::CARRY_FLOOR)) ? cbr_pkg::CARRY_FLOOR
                                                                  : carry_diff[CARRY_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbr_pkg::ST_IDLE: begin
                if (in_fire && (s_tuser == cbr_pkg::OP_TICK)) begin
                    state_next = cbr_pkg::ST_WALK_RD;
                end
            end
            cbr_pkg::ST_WALK_RD: begin
                state_next = walk_more ? cbr_pkg::ST_WALK_CHK : cbr_pkg::ST_FINISH;
            end
            cbr_pkg::ST_WALK_CHK: begin
                if (rd_before_tick) begin
                    state_next = cbr_pkg::ST_WALK_RD;
                end else if (ptr_reg == '0) begin
                    state_next = cbr_pkg::ST_EVAL;
                end else begin
                    state_next = cbr_pkg::ST_PREV;
                end
            end
            cbr_pkg::ST_PREV: begin
                state_next = cbr_pkg::ST_EVAL;
            end
            cbr_pkg::ST_EVAL: begin
                if ((CALC_W'(tick_reg) >= CALC_W'(nf_reg)) || (tick_s <= pf_s)) begin
                    state_next = cbr_pkg::ST_FINISH;
                end else begin
                    state_next = cbr_pkg::ST_MUL;
                end
            end
            cbr_pkg::ST_MUL: begin
                state_next = cbr_pkg::ST_DIV;
            end
            cbr_pkg::ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = cbr_pkg::ST_ADD;
                end
            end
            cbr_pkg::ST_ADD: begin
                state_next = cbr_pkg::ST_FINISH;
            end
            cbr_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = cbr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cbr_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        fpb_next         = fpb_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        tick_next        = tick_reg;
        carry_frame_next = carry_frame_reg;
        carry_level_next = carry_level_reg;
        last_bp_next     = last_bp_reg;
        nf_next          = nf_reg;
        nv_next          = nv_reg;
        pf_next          = pf_reg;
        pv_next          = pv_reg;
        span_next        = span_reg;
        dt_next          = dt_reg;
        dv_mag_next      = dv_mag_reg;
        neg_next         = neg_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg;
        m_level_next     = m_level_reg;
        m_last_next      = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && (cfg_index == cbr_pkg::CFG_FRAMES_PER_BUFFER)) begin
            fpb_next = cfg_data[cbr_pkg::CFG_FRAMES_W-1:0];
        end

        case (state_reg)
            cbr_pkg::ST_IDLE: begin
                if (ram_we) begin
                    count_next   = count_reg + 1'b1;
                    last_bp_next = in_entry;
                end
            end
            cbr_pkg::ST_WALK_RD: begin
                // past every stored breakpoint: hold the last level
                if (!walk_more) begin
                    res_next = (count_reg == '0) ? carry_level_reg : last_bp_reg.level;
                end
            end
            cbr_pkg::ST_WALK_CHK: begin
                if (rd_before_tick) begin
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    nf_next = rd_entry.frame;
                    nv_next = rd_entry.level;
                    // first segment starts at the carried breakpoint
                    pf_next = carry_frame_reg;
                    pv_next = carry_level_reg;
                end
            end
            cbr_pkg::ST_PREV: begin
                pf_next = CARRY_W'(rd_entry.frame);
                pv_next = rd_entry.level;
            end
            cbr_pkg::ST_EVAL: begin
                if (CALC_W'(tick_reg) >= CALC_W'(nf_reg)) begin
                    res_next = nv_reg;
                end else if (tick_s <= pf_s) begin
                    res_next = pv_reg;
                end
                span_next   = span_full[SPAN_W-1:0];
                dt_next     = dt_full[SPAN_W-1:0];
                neg_next    = dv[DIFF_W-1];
                dv_mag_next = dv[DIFF_W-1] ? LEVEL_W'(-dv) : dv[LEVEL_W-1:0];
            end
            cbr_pkg::ST_MUL: begin
                quo_next     = product;
                rem_next     = '0;
                div_cnt_next = DIV_CNT_W'(PROD_W - 1);
            end
            cbr_pkg::ST_DIV: begin
                rem_next     = quo_bit ? rem_sub[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
                quo_next     = {quo_reg[PROD_W-2:0], quo_bit};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            cbr_pkg::ST_ADD: begin
                res_next = ramp_sum[LEVEL_W-1:0];
            end
            cbr_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_level_next = res_reg;
                    m_last_next  = last_tick;
                    if (last_tick) begin
                        // carry the last breakpoint into the next buffer
                        if (count_reg != '0) begin
                            carry_level_next = last_bp_reg.level;
                        end
                        carry_frame_next = carry_sat;
                        count_next       = '0;
                        ptr_next         = '0;
                        tick_next        = '0;
                    end else begin
                        tick_next = tick_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= cbr_pkg::ST_IDLE;
            fpb_reg         <= cbr_pkg::FRAMES_RESET;
            count_reg       <= '0;
            ptr_reg         <= '0;
            tick_reg        <= '0;
            carry_frame_reg <= '0;
            carry_level_reg <= cbr_pkg::INITIAL_LEVEL_RESET;
            div_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            fpb_reg         <= fpb_next;
            count_reg       <= count_next;
            ptr_reg         <= ptr_next;
            tick_reg        <= tick_next;
            carry_frame_reg <= carry_frame_next;
            carry_level_reg <= carry_level_next;
            div_cnt_reg     <= div_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        last_bp_reg <= last_bp_next;
        nf_reg      <= nf_next;
        nv_reg      <= nv_next;
        pf_reg      <= pf_next;
        pv_reg      <= pv_next;
        span_reg    <= span_next;
        dt_reg      <= dt_next;
        dv_mag_reg  <= dv_mag_next;
        neg_reg     <= neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
        m_level_reg <= m_level_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = cbr_pkg::M_TDATA_W'(m_level_reg);
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/cbr_checker.sv
`include "control_breakpoint_ramp_core_assert.svh"

module cbr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cbr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // a stalled result word holds
    `CBR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // a tick keeps the block busy after it is taken
    `CBR_ASSERT_NEXT(a_tick_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == cbr_pkg::OP_TICK), !s_tready ##1 !s_tready)

    // a breakpoint leaves the block ready for the next word
    `CBR_ASSERT_NEXT(a_bp_single, aclk, aresetn, s_tvalid && s_tready && (s_tuser == cbr_pkg::OP_BREAKPOINT), s_tready)

    // a new result word appears only at the end of a tick
    `CBR_ASSERT_IMPLIES(a_out_from_tick, aclk, aresetn, $rose(m_tvalid), !$past(s_tready))

endmodule

bind control_breakpoint_ramp_core cbr_checker u_cbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
